/* rtl/cbsm_pkg.sv */
// Package for the cartridge bank-switch mapper.
// Holds mapping-mode and target codes, shared structs and the slot reload table.
// No dependencies.
package cbsm_pkg;

   localparam int unsigned ADDR_W    = 13;
   localparam int unsigned DATA_W    = 8;
   localparam int unsigned TARGET_W  = 3;
   localparam int unsigned ROM_ADDR_W = 16;
   localparam int unsigned RAM_ADDR_W = 10;
   localparam int unsigned SLOT_W    = 6;
   localparam int unsigned SLOTS     = 4;
   localparam int unsigned CNT_W     = 4;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DATA_W = 4;
   localparam int unsigned SLICE_BYTES = 1024;
   localparam int unsigned RAM_CHUNK = 128;

   localparam logic [CSR_IDX_W-1:0] CSR_MAP_MODE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SUPER_RAM = 1'b1;

   typedef enum logic [3:0] {
      MODE_2K  = 4'd0,
      MODE_4K  = 4'd1,
      MODE_8K  = 4'd2,
      MODE_12K = 4'd3,
      MODE_16K = 4'd4,
      MODE_32K = 4'd5,
      MODE_FIX = 4'd6,
      MODE_E0  = 4'd7,
      MODE_3F  = 4'd8,
      MODE_UA  = 4'd9,
      MODE_MN  = 4'd10,
      MODE_DC  = 4'd11,
      MODE_CV  = 4'd12
   } mode_type;

   typedef enum logic [TARGET_W-1:0] {
      TGT_NONE  = 3'd0,
      TGT_ROM   = 3'd1,
      TGT_RAMRD = 3'd2,
      TGT_RAMWR = 3'd3,
      TGT_HOT   = 3'd4,
      TGT_CNT   = 3'd5,
      TGT_IGN   = 3'd6
   } target_type;

   typedef struct packed {
      mode_type                         map_mode;
      logic                             super_ram_enable;
      logic [SLOTS-1:0][SLOT_W-1:0]     slot_base;
      logic [CNT_W-1:0]                 bank_counter;
   } map_state_type;

   typedef struct packed {
      logic                slot_we;
      logic [1:0]          slot_idx;
      logic [SLOT_W-1:0]   slot_val;
      logic                cnt_we;
      logic [CNT_W-1:0]    cnt_val;
   } map_update_type;

   typedef struct packed {
      target_type              target;
      logic [ROM_ADDR_W-1:0]   rom_address;
      logic [RAM_ADDR_W-1:0]   ram_address;
      logic [DATA_W-1:0]       read_value;
   } map_result_type;

   function automatic logic [SLOT_W-1:0] init_base(input mode_type m,
                                                   input logic [CNT_W-1:0] cnt);
      logic [SLOT_W-1:0] b;
      unique case (m)
         MODE_8K:  b = 6'd4;
         MODE_12K: b = 6'd8;
         MODE_16K: b = 6'd12;
         MODE_32K: b = 6'd28;
         MODE_E0:  b = 6'd7;
         MODE_3F:  b = 6'd6;
         MODE_UA:  b = 6'd4;
         MODE_MN:  b = 6'd14;
         MODE_DC:  b = {cnt, 2'b00};
         default:  b = 6'd0;
      endcase
      return b;
   endfunction

endpackage

/* rtl/cbsm_if.sv */
// Valid/ready channel interfaces for the mapper: bus access in, decode result
// out, register writes. Depends on cbsm_pkg.
interface cbsm_req_if;
   logic                             valid;
   logic                             ready;
   logic                             action;
   logic [cbsm_pkg::ADDR_W-1:0]      bus_address;
   logic [cbsm_pkg::DATA_W-1:0]      write_value;
   modport source (output valid, action, bus_address, write_value, input ready);
   modport sink (input valid, action, bus_address, write_value, output ready);
endinterface

interface cbsm_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [cbsm_pkg::TARGET_W-1:0]    target;
   logic [cbsm_pkg::ROM_ADDR_W-1:0]  rom_address;
   logic [cbsm_pkg::RAM_ADDR_W-1:0]  ram_address;
   logic [cbsm_pkg::DATA_W-1:0]      read_value;
   modport source (output valid, target, rom_address, ram_address, read_value,
                   input ready);
   modport sink (input valid, target, rom_address, ram_address, read_value,
                 output ready);
endinterface

interface cbsm_csr_if;
   logic                             valid;
   logic                             ready;
   logic [cbsm_pkg::CSR_IDX_W-1:0]   index;
   logic [cbsm_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* rtl/cartridge_bank_switch_mapper.sv */
// Top level of the cartridge bank-switch mapper.
// Holds the access and result registers around the decode and state units.
// Depends on cbsm_pkg, cbsm_if, cbsm_state and cbsm_decode.
//
// Usage:
//   req_bus carries one CPU bus access (action, bus_address, write_value);
//   rsp_bus returns one decode item per access: target, ROM offset, RAM
//   offset and the byte the mapper drives. csr_bus writes map_mode (index 0)
//   and super_ram_enable (index 1); it is always ready, and a mode write
//   reloads the slot bases of that mode.
//   An accepted access is registered in the access register, decoded against
//   the slot bases and bank counter, and its result is loaded into the result
//   register. Throughput is one access per cycle while rsp_bus does not stall;
//   slot and counter updates land at the same edge as the result unless a
//   csr_bus write is taken at that edge, so the next access sees them.
//   Reset selects the 4K mode, clears the counter and super-chip enable and
//   loads the 4K slot bases. When rsp_bus stalls, the result register and
//   the access register both hold; req_bus ready drops once both are full.
module cartridge_bank_switch_mapper #(
   parameter int unsigned ROM_BYTES = 65536,
   parameter int unsigned RAM_BYTES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   cbsm_req_if.sink    req_bus,
   cbsm_rsp_if.source  rsp_bus,
   cbsm_csr_if.sink    csr_bus
);

   logic                              s1_valid_ff, s1_valid_in;
   logic                              s1_action_ff, s1_action_in;
   logic [cbsm_pkg::ADDR_W-1:0]       s1_addr_ff, s1_addr_in;
   logic [cbsm_pkg::DATA_W-1:0]       s1_data_ff, s1_data_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   cbsm_pkg::map_result_type          rsp_ff, rsp_in;
   logic                              req_acc;
   logic                              s1_adv;
   cbsm_pkg::map_state_type           state;
   cbsm_pkg::map_result_type          result;
   cbsm_pkg::map_update_type          upd;

   assign s1_adv        = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || s1_adv;
   assign req_acc       = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   cbsm_state u_state (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_bus.valid),
      .csr_index (csr_bus.index),
      .csr_data  (csr_bus.data),
      .upd_en    (s1_adv),
      .upd       (upd),
      .state     (state)
   );

   cbsm_decode #(
      .ROM_BYTES (ROM_BYTES),
      .RAM_BYTES (RAM_BYTES)
   ) u_decode (
      .action      (s1_action_ff),
      .bus_address (s1_addr_ff),
      .write_value (s1_data_ff),
      .state       (state),
      .result      (result),
      .upd         (upd)
   );

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_action_in = s1_action_ff;
      s1_addr_in   = s1_addr_ff;
      s1_data_in   = s1_data_ff;
      if (req_acc) begin
         s1_valid_in  = 1'b1;
         s1_action_in = req_bus.action;
         s1_addr_in   = req_bus.bus_address;
         s1_data_in   = req_bus.write_value;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_action_ff <= s1_action_in;
      s1_addr_ff   <= s1_addr_in;
      s1_data_ff   <= s1_data_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.target      = rsp_ff.target;
   assign rsp_bus.rom_address = rsp_ff.rom_address;
   assign rsp_bus.ram_address = rsp_ff.ram_address;
   assign rsp_bus.read_value  = rsp_ff.read_value;

endmodule

/* rtl/cbsm_state.sv */
// Mapper state: mode, super-chip enable, slot bases and bank counter.
// Takes register writes and per-item updates. Depends on cbsm_pkg.
module cbsm_state (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [cbsm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cbsm_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                              upd_en,
   input  cbsm_pkg::map_update_type          upd,
   output cbsm_pkg::map_state_type           state
);

   cbsm_pkg::map_state_type state_ff, state_in;
   cbsm_pkg::mode_type      new_mode;
   logic [cbsm_pkg::SLOT_W-1:0] new_base;

   always_comb begin
      if (csr_data > 4'(cbsm_pkg::MODE_CV)) begin
         new_mode = cbsm_pkg::MODE_FIX;
      end else begin
         new_mode = cbsm_pkg::mode_type'(csr_data);
      end
      new_base = cbsm_pkg::init_base(new_mode, state_ff.bank_counter);
   end

   always_comb begin
      state_in = state_ff;
      if (csr_we) begin
         unique case (csr_index)
            cbsm_pkg::CSR_MAP_MODE: begin
               state_in.map_mode  = new_mode;
               state_in.slot_base = {cbsm_pkg::SLOTS{new_base}};
            end
            cbsm_pkg::CSR_SUPER_RAM: begin
               state_in.super_ram_enable = csr_data[0];
            end
            default: begin
            end
         endcase
      end else if (upd_en) begin
         if (upd.slot_we) begin
            state_in.slot_base[upd.slot_idx] = upd.slot_val;
         end
         if (upd.cnt_we) begin
            state_in.bank_counter = upd.cnt_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.map_mode         <= cbsm_pkg::MODE_4K;
         state_ff.super_ram_enable <= 1'b0;
         state_ff.bank_counter     <= '0;
         state_ff.slot_base        <= {cbsm_pkg::SLOTS{
                                         cbsm_pkg::init_base(cbsm_pkg::MODE_4K, '0)}};
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

/* rtl/cbsm_decode.sv */
// Single-pass decode of one bus access against the current mapper state.
// Gives the result item and the state update. Depends on cbsm_pkg.
module cbsm_decode #(
   parameter int unsigned ROM_BYTES = 65536,
   parameter int unsigned RAM_BYTES = 1024
) (
   input  logic                             action,
   input  logic [cbsm_pkg::ADDR_W-1:0]      bus_address,
   input  logic [cbsm_pkg::DATA_W-1:0]      write_value,
   input  cbsm_pkg::map_state_type          state,
   output cbsm_pkg::map_result_type         result,
   output cbsm_pkg::map_update_type         upd
);

   localparam int unsigned ROM_TAB_N = 128;
   localparam int unsigned RAM_TAB_N = 8;
   localparam logic [cbsm_pkg::ROM_ADDR_W:0] ROM_LIM = (cbsm_pkg::ROM_ADDR_W + 1)'(ROM_BYTES);
   localparam logic [cbsm_pkg::RAM_ADDR_W:0] RAM_LIM = (cbsm_pkg::RAM_ADDR_W + 1)'(RAM_BYTES);

   logic [cbsm_pkg::ROM_ADDR_W-1:0] rom_tab [ROM_TAB_N];
   logic [cbsm_pkg::RAM_ADDR_W-1:0] ram_tab [RAM_TAB_N];

   for (genvar g = 0; g < ROM_TAB_N; g++) begin : g_rom_tab
      localparam int unsigned V = (g * cbsm_pkg::SLICE_BYTES) % ROM_BYTES;
      assign rom_tab[g] = cbsm_pkg::ROM_ADDR_W'(V);
   end

   for (genvar g = 0; g < RAM_TAB_N; g++) begin : g_ram_tab
      localparam int unsigned V = (g * cbsm_pkg::RAM_CHUNK) % RAM_BYTES;
      assign ram_tab[g] = cbsm_pkg::RAM_ADDR_W'(V);
   end

   cbsm_pkg::mode_type mode;
   logic [11:0]        off;
   logic [11:0]        hs_diff;
   logic               hs_hit;
   cbsm_pkg::map_update_type hs_upd;
   logic [cbsm_pkg::CNT_W-1:0] cnt_next;
   logic [1:0]         slot_idx;
   logic [1:0]         low_hi;
   logic [6:0]         k;
   logic [cbsm_pkg::ROM_ADDR_W:0] rom_sum;
   logic [cbsm_pkg::ROM_ADDR_W-1:0] rom_mod;
   logic [cbsm_pkg::RAM_ADDR_W-1:0] ram_raw;
   logic [cbsm_pkg::RAM_ADDR_W:0]   ram_sum;
   logic [cbsm_pkg::RAM_ADDR_W-1:0] ram_mod;

   assign mode     = state.map_mode;
   assign off      = bus_address[11:0];
   assign cnt_next = state.bank_counter + 4'd1;

   // hotspot match per mode
   always_comb begin
      hs_hit  = 1'b0;
      hs_upd  = '0;
      hs_diff = '0;
      case (mode)
         cbsm_pkg::MODE_8K: begin
            hs_diff = off - 12'hFF8;
            hs_hit  = (off >= 12'hFF8) && (off <= 12'hFF9);
         end
         cbsm_pkg::MODE_12K: begin
            hs_diff = off - 12'hFF8;
            hs_hit  = (off >= 12'hFF8) && (off <= 12'hFFA);
         end
         cbsm_pkg::MODE_16K: begin
            hs_diff = off - 12'hFF6;
            hs_hit  = (off >= 12'hFF6) && (off <= 12'hFF9);
         end
         cbsm_pkg::MODE_32K: begin
            hs_diff = off - 12'hFF4;
            hs_hit  = (off >= 12'hFF4) && (off <= 12'hFFB);
         end
         default: begin
         end
      endcase
      hs_upd.slot_we  = hs_hit;
      hs_upd.slot_idx = 2'd0;
      hs_upd.slot_val = {1'b0, hs_diff[2:0], 2'b00};
      case (mode)
         cbsm_pkg::MODE_E0: begin
            hs_hit          = (off >= 12'hFE0) && (off <= 12'hFF7);
            hs_upd.slot_we  = hs_hit;
            hs_upd.slot_idx = off[4:3];
            hs_upd.slot_val = {3'b000, off[2:0]};
         end
         cbsm_pkg::MODE_MN: begin
            hs_hit          = (off >= 12'hFE0) && (off <= 12'hFE7);
            hs_upd.slot_we  = hs_hit;
            hs_upd.slot_idx = 2'd0;
            hs_upd.slot_val = {2'b00, off[2:0], 1'b0};
         end
         cbsm_pkg::MODE_DC: begin
            hs_hit          = (off == 12'hFF0);
            hs_upd.slot_we  = hs_hit;
            hs_upd.slot_idx = 2'd0;
            hs_upd.slot_val = {cnt_next, 2'b00};
            hs_upd.cnt_we   = hs_hit;
            hs_upd.cnt_val  = cnt_next;
         end
         default: begin
         end
      endcase
   end

   // ROM offset: slot base plus offset within the slot, wrapped to ROM size
   always_comb begin
      unique case (mode) inside
         cbsm_pkg::MODE_2K, cbsm_pkg::MODE_3F, cbsm_pkg::MODE_MN, cbsm_pkg::MODE_CV: begin
            slot_idx = {1'b0, off[11]};
            low_hi   = {1'b0, off[10]};
         end
         cbsm_pkg::MODE_E0: begin
            slot_idx = off[11:10];
            low_hi   = 2'd0;
         end
         default: begin
            slot_idx = 2'd0;
            low_hi   = off[11:10];
         end
      endcase
      k       = {1'b0, state.slot_base[slot_idx]} + {5'b0, low_hi};
      rom_sum = {1'b0, rom_tab[k]} + (cbsm_pkg::ROM_ADDR_W + 1)'(off[9:0]);
      if (rom_sum >= ROM_LIM) begin
         rom_mod = cbsm_pkg::ROM_ADDR_W'(rom_sum - ROM_LIM);
      end else begin
         rom_mod = cbsm_pkg::ROM_ADDR_W'(rom_sum);
      end
   end

   // RAM offset wrapped to RAM size
   always_comb begin
      ram_sum = {1'b0, ram_tab[ram_raw[9:7]]} + (cbsm_pkg::RAM_ADDR_W + 1)'(ram_raw[6:0]);
      if (ram_sum >= RAM_LIM) begin
         ram_mod = cbsm_pkg::RAM_ADDR_W'(ram_sum - RAM_LIM);
      end else begin
         ram_mod = cbsm_pkg::RAM_ADDR_W'(ram_sum);
      end
   end

   always_comb begin
      result  = '0;
      upd     = '0;
      ram_raw = '0;
      if (mode == cbsm_pkg::MODE_3F && action && bus_address < 13'h0040) begin
         result.target = cbsm_pkg::TGT_HOT;
         upd.slot_we   = 1'b1;
         upd.slot_idx  = 2'd0;
         upd.slot_val  = {3'b000, write_value[1:0], 1'b0};
      end else if (mode == cbsm_pkg::MODE_UA && bus_address >= 13'h0200
                   && bus_address <= 13'h027F) begin
         result.target = cbsm_pkg::TGT_HOT;
         upd.slot_we   = 1'b1;
         upd.slot_idx  = 2'd0;
         upd.slot_val  = bus_address[6] ? 6'd4 : 6'd0;
      end else if (!bus_address[12]) begin
         result.target = cbsm_pkg::TGT_NONE;
      end else if (state.super_ram_enable && action && off < 12'h080) begin
         result.target = cbsm_pkg::TGT_RAMWR;
         ram_raw       = {3'b000, off[6:0]};
      end else if (state.super_ram_enable && !action && off >= 12'h080
                   && off <= 12'h0FF) begin
         result.target = cbsm_pkg::TGT_RAMRD;
         ram_raw       = {3'b000, off[6:0]};
      end else if (mode == cbsm_pkg::MODE_12K && action && off < 12'h100) begin
         result.target = cbsm_pkg::TGT_RAMWR;
         ram_raw       = {2'b00, off[7:0]};
      end else if (mode == cbsm_pkg::MODE_12K && !action && off[11:8] == 4'h1) begin
         result.target = cbsm_pkg::TGT_RAMRD;
         ram_raw       = {2'b00, off[7:0]};
      end else if (mode == cbsm_pkg::MODE_CV && !action && off < 12'h400) begin
         result.target = cbsm_pkg::TGT_RAMRD;
         ram_raw       = off[9:0];
      end else if (mode == cbsm_pkg::MODE_CV && action && off[11:10] == 2'b01) begin
         result.target = cbsm_pkg::TGT_RAMWR;
         ram_raw       = off[9:0];
      end else if (hs_hit) begin
         result.target = cbsm_pkg::TGT_HOT;
         upd           = hs_upd;
      end else if (mode == cbsm_pkg::MODE_DC && off == 12'hFEC && !action) begin
         result.target     = cbsm_pkg::TGT_CNT;
         result.read_value = {4'b0000, state.bank_counter};
      end else if (action) begin
         result.target = cbsm_pkg::TGT_IGN;
      end else begin
         result.target      = cbsm_pkg::TGT_ROM;
         result.rom_address = rom_mod;
      end
      if (result.target == cbsm_pkg::TGT_RAMRD || result.target == cbsm_pkg::TGT_RAMWR) begin
         result.ram_address = ram_mod;
      end
   end

endmodule
